[hw/rtl/pdq_pkg.sv]
package pdq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
  localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
  localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
  localparam logic [3:0] MODE_POP_BACK   = 4'd3;
  localparam logic [3:0] MODE_INSERT     = 4'd4;
  localparam logic [3:0] MODE_REMOVE     = 4'd5;
  localparam logic [3:0] MODE_READ       = 4'd6;
  localparam logic [3:0] MODE_REVERSE    = 4'd7;
  localparam logic [3:0] MODE_CLEAR      = 4'd8;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_PAST  = 2'd3;

  typedef struct packed {
    logic [3:0]  mode;
    logic [5:0]  position;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[hw/rtl/positional_deque_core.sv]
// channel   ports                          handshake
// request   request (mode,position,value)  taken when start && !busy
// result    result (read_value,entry_count,status)  valid for the one cycle done is high
//
// Clear, unused modes and every rejected request are answered straight from idle.
// Push-front/insert shift later entries up, a read then a write per move, then write the word;
// pop-front/remove shift later entries down the same way; read reads, then captures; reverse
// reads both ends of a pair, then writes both, since the entry memory's read is registered.
// Synchronous rst clears count and the sequencer; entry contents are kept.
// The receiver cannot stall; done pulses once per request.
module positional_deque_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  pdq_pkg::req_t request,
  output logic          busy,
  output logic          done,
  output pdq_pkg::rsp_t result
);
  import pdq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_WR, S_PUT_WR, S_DN_RD, S_DN_WR,
    S_RD_RD, S_RD_CAP, S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  lim;
  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] tmp;
  logic [DATA_W-1:0] rdval;
  logic [1:0]        status;
  logic [DATA_W-1:0] rdata;
  mem_req_t          mreq;

  logic [CNT_W-1:0] pos;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] lim_dec;
  logic [CNT_W-1:0] cnt_dec;
  logic             pos_in;

  assign pos     = CNT_W'(request.position);
  assign idx_inc = idx + CNT_W'(1);
  assign idx_dec = idx - CNT_W'(1);
  assign lim_dec = lim - CNT_W'(1);
  assign cnt_dec = count - CNT_W'(1);
  assign pos_in  = pos < count;

  pdq_mem u_mem (
    .clk  (clk),
    .mreq (mreq),
    .rdata(rdata)
  );

  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = idx[ADDR_W-1:0];
    mreq.wdata = rdata;
    mreq.raddr = idx[ADDR_W-1:0];
    case (state)
      S_UP_RD:  mreq.raddr = idx_dec[ADDR_W-1:0];
      S_UP_WR:  mreq.we = 1'b1;
      S_PUT_WR: begin
        mreq.we    = 1'b1;
        mreq.waddr = lim[ADDR_W-1:0];
        mreq.wdata = word;
      end
      S_DN_RD:  mreq.raddr = idx_inc[ADDR_W-1:0];
      S_DN_WR:  mreq.we = 1'b1;
      S_SW_RB:  mreq.raddr = lim[ADDR_W-1:0];
      S_SW_WA:  mreq.we = 1'b1;
      S_SW_WB: begin
        mreq.we    = 1'b1;
        mreq.waddr = lim[ADDR_W-1:0];
        mreq.wdata = tmp;
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);
  assign result.read_value  = 32'(rdval);
  assign result.entry_count = 7'(count);
  assign result.status      = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      done   <= 1'b0;
      status <= ST_DONE;
      rdval  <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            rdval  <= '0;
            status <= ST_DONE;
            case (request.mode)
              MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
                word <= DATA_W'(request.value);
                idx  <= count;
                if (count == CNT_W'(CAPACITY)) begin
                  status <= ST_FULL;
                  done   <= 1'b1;
                end else if (request.mode == MODE_PUSH_FRONT) begin
                  lim   <= '0;
                  state <= (count != '0) ? S_UP_RD : S_PUT_WR;
                end else if (request.mode == MODE_INSERT && pos_in) begin
                  lim   <= pos;
                  state <= S_UP_RD;
                end else begin
                  lim   <= count;
                  state <= S_PUT_WR;
                end
              end
              MODE_POP_FRONT, MODE_POP_BACK, MODE_REMOVE: begin
                lim <= cnt_dec;
                if (count == '0) begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end else if (request.mode == MODE_REMOVE && !pos_in) begin
                  status <= ST_PAST;
                  done   <= 1'b1;
                end else if (request.mode == MODE_POP_BACK) begin
                  count <= cnt_dec;
                  done  <= 1'b1;
                end else begin
                  idx <= (request.mode == MODE_POP_FRONT) ? '0 : pos;
                  if ((request.mode == MODE_POP_FRONT ? '0 : pos) < cnt_dec) begin
                    state <= S_DN_RD;
                  end else begin
                    count <= cnt_dec;
                    done  <= 1'b1;
                  end
                end
              end
              MODE_READ: begin
                if (count == '0) begin
                  status <= ST_EMPTY;
                  done   <= 1'b1;
                end else begin
                  idx   <= pos_in ? pos : cnt_dec;
                  state <= S_RD_RD;
                end
              end
              MODE_REVERSE: begin
                idx <= '0;
                lim <= cnt_dec;
                if (count > CNT_W'(1)) begin
                  state <= S_SW_RA;
                end else begin
                  done <= 1'b1;
                end
              end
              MODE_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          idx   <= idx_dec;
          state <= (idx_dec == lim) ? S_PUT_WR : S_UP_RD;
        end
        S_PUT_WR: begin
          count <= count + CNT_W'(1);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_DN_RD: state <= S_DN_WR;
        S_DN_WR: begin
          idx <= idx_inc;
          if (idx_inc == lim) begin
            count <= cnt_dec;
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_RD_RD: state <= S_RD_CAP;
        S_RD_CAP: begin
          rdval <= rdata;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_SW_RA: state <= S_SW_RB;
        S_SW_RB: begin
          tmp   <= rdata;
          state <= S_SW_WA;
        end
        S_SW_WA: state <= S_SW_WB;
        S_SW_WB: begin
          idx <= idx_inc;
          lim <= lim_dec;
          if (idx_inc < lim_dec) begin
            state <= S_SW_RA;
          end else begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/pdq_mem.sv]
module pdq_mem (
  input  logic                      clk,
  input  pdq_pkg::mem_req_t         mreq,
  output logic [pdq_pkg::DATA_W-1:0] rdata
);
  import pdq_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (mreq.we) begin
      mem[mreq.waddr] <= mreq.wdata;
    end
    rdata <= mem[mreq.raddr];
  end

endmodule

[tb/sv/positional_deque_core_tb.sv]
`timescale 1ns / 100ps

module positional_deque_core_tb;
  import pdq_pkg::*;

  localparam int ITEM_TARGET    = 1950;
  localparam int IDLE_PCT       = 18;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 200;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  req_t  request = '0;
  logic  busy;
  logic  done;
  rsp_t  result;

  req_t        req_pending_q[$];
  rsp_t        expected_rsp_q[$];
  logic [31:0] deque_entries_q[$];
  rsp_t        rsp_pred;
  rsp_t        rsp_want;
  logic        req_taken = 1'b0;
  int          req_sent = 0;
  int          useful_items = 0;
  int          err_cnt = 0;
  int          quiet_cycles = 0;

  positional_deque_core dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  task automatic predict_op(input req_t r, output rsp_t rsp);
    int unsigned n;
    int unsigned p;
    int a;
    int b;
    logic [31:0] t;
    rsp = '0;
    rsp.status = ST_DONE;
    n = deque_entries_q.size();
    p = 32'(r.position);
    case (r.mode)
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_INSERT: begin
        if (n >= CAPACITY) rsp.status = ST_FULL;
        else if (r.mode == MODE_PUSH_FRONT) deque_entries_q.push_front(r.value);
        else if (r.mode == MODE_PUSH_BACK) deque_entries_q.push_back(r.value);
        else deque_entries_q.insert((p < n) ? p : n, r.value);
      end
      MODE_POP_FRONT: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(deque_entries_q.pop_front());
      end
      MODE_POP_BACK: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else void'(deque_entries_q.pop_back());
      end
      MODE_REMOVE: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else if (p >= n) rsp.status = ST_PAST;
        else deque_entries_q.delete(p);
      end
      MODE_READ: begin
        if (n == 0) rsp.status = ST_EMPTY;
        else rsp.read_value = deque_entries_q[(p < n) ? p : n - 1];
      end
      MODE_REVERSE: begin
        a = 0;
        b = int'(n) - 1;
        while (a < b) begin
          t = deque_entries_q[a];
          deque_entries_q[a] = deque_entries_q[b];
          deque_entries_q[b] = t;
          a++;
          b--;
        end
      end
      MODE_CLEAR: deque_entries_q.delete();
      default: ;
    endcase
    rsp.entry_count = 7'(deque_entries_q.size());
  endtask

  task automatic add_req(input logic [3:0] mode, input logic [5:0] pos,
                         input logic [31:0] val);
    req_t r;
    r.mode = mode;
    r.position = pos;
    r.value = val;
    req_pending_q.push_back(r);
  endtask

  // grow_pct: share of push/insert requests; the rest mostly shrink or read
  task automatic add_random_phase(input int n_items, input int grow_pct);
    req_t r;
    int k;
    int i;
    for (i = 0; i < n_items; i++) begin
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 1) == 0) r.position = 6'($urandom_range(0, 63));
      else r.position = 6'($urandom_range(0, 7));
      case ($urandom_range(0, 9))
        0: r.value = '0;
        1: r.value = '1;
        default: r.value = $urandom;
      endcase
      if (k < grow_pct) begin
        case ($urandom_range(0, 2))
          0: r.mode = MODE_PUSH_FRONT;
          1: r.mode = MODE_PUSH_BACK;
          default: r.mode = MODE_INSERT;
        endcase
      end else if (k < 94) begin
        case ($urandom_range(0, 4))
          0: r.mode = MODE_POP_FRONT;
          1: r.mode = MODE_POP_BACK;
          2: r.mode = MODE_REMOVE;
          default: r.mode = MODE_READ;
        endcase
      end else if (k < 98) begin
        r.mode = MODE_REVERSE;
      end else if (k < 99) begin
        r.mode = 4'($urandom_range(9, 15));
      end else begin
        r.mode = MODE_CLEAR;
      end
      req_pending_q.push_back(r);
      if (r.mode <= MODE_CLEAR) useful_items++;
    end
  endtask

  // driver: a raised start is held until the request is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || req_taken) begin
      if (req_pending_q.size() != 0 &&
          !((req_sent < 700 || req_sent >= 1100) && $urandom_range(0, 99) < IDLE_PCT)) begin
        start   <= 1'b1;
        request <= req_pending_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    req_taken <= !rst && start && !busy;
    if (!rst) begin
      if (start && !busy) begin
        predict_op(request, rsp_pred);
        expected_rsp_q.push_back(rsp_pred);
        req_sent++;
      end
      if (done) begin
        if (expected_rsp_q.size() == 0) begin
          $error("unexpected result: read_value %0h entry_count %0d status %0d",
                 result.read_value, result.entry_count, result.status);
          err_cnt++;
        end else begin
          rsp_want = expected_rsp_q.pop_front();
          if (result.read_value !== rsp_want.read_value) begin
            $error("read_value mismatch: expected %0h, got %0h",
                   rsp_want.read_value, result.read_value);
            err_cnt++;
          end
          if (result.entry_count !== rsp_want.entry_count) begin
            $error("entry_count mismatch: expected %0d, got %0d",
                   rsp_want.entry_count, result.entry_count);
            err_cnt++;
          end
          if (result.status !== rsp_want.status) begin
            $error("status mismatch: expected %0d, got %0d",
                   rsp_want.status, result.status);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int phase;
    phase = 0;

    // empty-list cases
    add_req(MODE_READ, 6'd0, 32'h0);
    add_req(MODE_POP_FRONT, 6'd0, 32'h0);
    add_req(MODE_POP_BACK, 6'd0, 32'h0);
    add_req(MODE_REMOVE, 6'd5, 32'h0);
    add_req(MODE_REVERSE, 6'd0, 32'h0);
    add_req(MODE_CLEAR, 6'd0, 32'h0);
    // build a short list, then work every mode on it; insert past end appends
    add_req(MODE_PUSH_FRONT, 6'd0, 32'hFFFF_FFFF);
    add_req(MODE_PUSH_BACK, 6'd0, 32'h0);
    add_req(MODE_INSERT, 6'd63, 32'hA5A5_A5A5);
    add_req(MODE_INSERT, 6'd0, 32'h1234_5678);
    add_req(MODE_INSERT, 6'd1, 32'hDEAD_BEEF);
    add_req(MODE_READ, 6'd0, 32'h0);
    add_req(MODE_READ, 6'd63, 32'h0);
    add_req(MODE_REMOVE, 6'd63, 32'h0);
    add_req(MODE_REMOVE, 6'd1, 32'h0);
    add_req(MODE_REVERSE, 6'd0, 32'h0);
    add_req(MODE_READ, 6'd2, 32'h0);
    add_req(MODE_POP_FRONT, 6'd0, 32'h0);
    add_req(MODE_POP_BACK, 6'd0, 32'h0);
    add_req(4'd9, 6'd0, 32'h0);
    add_req(4'd15, 6'd63, 32'hFFFF_FFFF);
    add_req(MODE_CLEAR, 6'd0, 32'h0);
    useful_items = 20;

    while (useful_items < ITEM_TARGET) begin
      case (phase % 3)
        0: add_random_phase($urandom_range(100, 180), 85);
        1: add_random_phase($urandom_range(60, 180), 50);
        default: add_random_phase($urandom_range(60, 140), 15);
      endcase
      phase++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (req_pending_q.size() != 0 || start || expected_rsp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_rsp_q.size() != 0) begin
      $error("%0d results never arrived", expected_rsp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[positional_deque_core.f]
hw/rtl/pdq_pkg.sv
hw/rtl/pdq_mem.sv
hw/rtl/positional_deque_core.sv
tb/sv/positional_deque_core_tb.sv
